/* src/cooling_fan_pump_gear_control_assert.svh */
// Assertion macros for the cooling fan and pump gear control block.
`ifndef COOLING_FAN_PUMP_GEAR_CONTROL_ASSERT_SVH
`define COOLING_FAN_PUMP_GEAR_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define CFPG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfpg assertion failed");
// Checked at every edge, reset included.
`define CFPG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cfpg assertion failed");
`else
`define CFPG_ASSERT(lbl, prop)
`define CFPG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* src/cfpg_pkg.sv */
// Shared constants, types and helpers for the cooling fan and pump gear control.
package cfpg_pkg;

  localparam int GEAR_COUNT = 4;
  localparam int GEAR_W = (GEAR_COUNT > 1) ? $clog2(GEAR_COUNT) : 1;
  localparam int BYTES_PER_WORD = 4;

  localparam logic [7:0] RAW_INVALID_FROM = 8'd220;
  localparam logic [8:0] TEMP_OFFSET = 9'd50;
  localparam logic [7:0] RUN_ON_STOP_RAW = 8'd100;
  localparam logic signed [9:0] HYSTERESIS = 10'sd3;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_GEAR_TEMP_LIMITS = 3'd0;
  localparam reg_idx_t REG_FAN_GEAR_SPEEDS = 3'd1;
  localparam reg_idx_t REG_PUMP_GEAR_SPEEDS = 3'd2;
  localparam reg_idx_t REG_ACTIVE_STATE_FLOOR = 3'd3;
  localparam reg_idx_t REG_ACTIVE_STATE_CEILING = 3'd4;

  typedef logic [GEAR_W-1:0] gear_t;
  typedef logic signed [8:0] temp_t;

  // Byte idx of a gear word; bytes past the word read as zero.
  function automatic logic [7:0] byte_of(input logic [31:0] word, input int idx);
    logic [7:0] b;
    b = 8'd0;
    if (idx >= 0 && idx < BYTES_PER_WORD) begin
      b = word[8*idx +: 8];
    end
    return b;
  endfunction

endpackage

/* src/cfpg_gear_sel.sv */
// Gear lookup: tracked temperature against limit bytes, then fan and pump bytes.
module cfpg_gear_sel (
  input  cfpg_pkg::temp_t  trk,
  input  logic [31:0]      limits,
  input  logic [31:0]      fan_speeds,
  input  logic [31:0]      pump_speeds,
  output logic [7:0]       fan,
  output logic [7:0]       pump
);

  cfpg_pkg::gear_t sel;

  always_comb begin
    sel = cfpg_pkg::gear_t'(cfpg_pkg::GEAR_COUNT - 1);
    for (int g = cfpg_pkg::GEAR_COUNT - 2; g >= 0; g--) begin
      if ($signed({trk[8], trk}) <= $signed({2'b00, cfpg_pkg::byte_of(limits, g)})) begin
        sel = cfpg_pkg::gear_t'(g);
      end
    end
    fan  = cfpg_pkg::byte_of(fan_speeds, int'(sel));
    pump = cfpg_pkg::byte_of(pump_speeds, int'(sel));
  end

endmodule

/* src/cooling_fan_pump_gear_control.sv */
// Cooling fan and pump gear control: input register, update logic, result register.
// Path: an accepted input passes the input register, then the result register, where it can wait on out_ready.
// Throughput: one item per cycle while out_ready is high; the state update is one pass of compare logic.
// Input accepted while a result waits only if the input register is empty.
// Reset: synchronous, active low; clears valid flags, run-on flag, tracked temperature,
// held speeds, gear shadows and configuration (ceiling resets to 255).
module cooling_fan_pump_gear_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_charger_state,
  input  logic [7:0]  in_raw_temperature,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_fan_pwm,
  output logic [7:0]  out_pump_pwm,
  output logic        out_cooling_on,
  input  logic        cfg_wr_en,
  input  cfpg_pkg::reg_idx_t cfg_index,
  input  logic [31:0] cfg_data
);

  `include "cooling_fan_pump_gear_control_assert.svh"

  logic [31:0] lim_r, fan_cfg_r, pump_cfg_r;
  logic [7:0]  floor_r, ceil_r;
  logic [31:0] sh_lim_r, sh_fan_r, sh_pump_r;

  logic        in_vld_r;
  logic [7:0]  st_r, raw_r;

  logic        run_on_r;
  cfpg_pkg::temp_t trk_r;
  logic [7:0]  held_fan_r, held_pump_r;

  logic        out_vld_r, on_r;
  logic [7:0]  fan_r, pump_r;

  logic        advance, fire;
  logic        in_win, raw_ok, running, big_move, run_on_nxt;
  logic [31:0] lim_eff, fan_eff, pump_eff;
  cfpg_pkg::temp_t cur, trk_nxt;
  logic signed [9:0] diff;
  logic [7:0]  gear_fan, gear_pump, held_fan_nxt, held_pump_nxt;

  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    in_win   = (st_r > floor_r) && (st_r < ceil_r);
    lim_eff  = in_win ? lim_r : sh_lim_r;
    fan_eff  = in_win ? fan_cfg_r : sh_fan_r;
    pump_eff = in_win ? pump_cfg_r : sh_pump_r;
    running  = in_win || (run_on_r && (raw_r >= cfpg_pkg::RUN_ON_STOP_RAW));
    run_on_nxt = running;
    raw_ok   = (raw_r != 8'd0) && (raw_r < cfpg_pkg::RAW_INVALID_FROM);
    cur      = $signed({1'b0, raw_r} - cfpg_pkg::TEMP_OFFSET);
    diff     = $signed({cur[8], cur}) - $signed({trk_r[8], trk_r});
    big_move = (diff >= cfpg_pkg::HYSTERESIS) || (diff <= -cfpg_pkg::HYSTERESIS);
    trk_nxt  = (running && raw_ok && big_move) ? cur : trk_r;
  end

  cfpg_gear_sel u_gear_sel (
    .trk         (trk_nxt),
    .limits      (lim_eff),
    .fan_speeds  (fan_eff),
    .pump_speeds (pump_eff),
    .fan         (gear_fan),
    .pump        (gear_pump)
  );

  always_comb begin
    held_fan_nxt  = (running && raw_ok) ? gear_fan : held_fan_r;
    held_pump_nxt = (running && raw_ok) ? gear_pump : held_pump_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r      <= 32'd0;
      fan_cfg_r  <= 32'd0;
      pump_cfg_r <= 32'd0;
      floor_r    <= 8'd0;
      ceil_r     <= 8'd255;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cfpg_pkg::REG_GEAR_TEMP_LIMITS:     lim_r      <= cfg_data;
        cfpg_pkg::REG_FAN_GEAR_SPEEDS:      fan_cfg_r  <= cfg_data;
        cfpg_pkg::REG_PUMP_GEAR_SPEEDS:     pump_cfg_r <= cfg_data;
        cfpg_pkg::REG_ACTIVE_STATE_FLOOR:   floor_r    <= cfg_data[7:0];
        cfpg_pkg::REG_ACTIVE_STATE_CEILING: ceil_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_r  <= in_charger_state;
      raw_r <= in_raw_temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_on_r    <= 1'b0;
      trk_r       <= '0;
      held_fan_r  <= 8'd0;
      held_pump_r <= 8'd0;
      sh_lim_r    <= 32'd0;
      sh_fan_r    <= 32'd0;
      sh_pump_r   <= 32'd0;
    end else if (fire) begin
      run_on_r    <= run_on_nxt;
      trk_r       <= trk_nxt;
      held_fan_r  <= held_fan_nxt;
      held_pump_r <= held_pump_nxt;
      if (in_win) begin
        sh_lim_r  <= lim_r;
        sh_fan_r  <= fan_cfg_r;
        sh_pump_r <= pump_cfg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fan_r  <= running ? held_fan_nxt : 8'd0;
      pump_r <= running ? held_pump_nxt : 8'd0;
      on_r   <= running;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_fan_pwm    = fan_r;
  assign out_pump_pwm   = pump_r;
  assign out_cooling_on = on_r;

  `CFPG_ASSERT(a_off_is_zero, out_vld_r && !on_r |-> fan_r == 8'd0 && pump_r == 8'd0)
  `CFPG_ASSERT(a_result_tracks_runon, fire |=> on_r == run_on_r)
  `CFPG_ASSERT(a_fire_fills_output, fire |=> out_vld_r)
  `CFPG_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_vld_r && !in_vld_r && !run_on_r)

endmodule
